// ===== rtl/gord_pkg.sv =====
// Shared types and constants for the glyph outline record decoder.
package gord_pkg;

   // Default depth of the command queue between parser and output stage (power of two, >= 2)
   localparam int QUEUE_DEPTH = 4;

   // Width of one outline word and of one coordinate
   localparam int WORD_W = 32;

   // One path command as it waits in the queue; y values are not yet flipped
   typedef struct packed {
      logic [1:0]        cmd;
      logic [WORD_W-1:0] px;
      logic [WORD_W-1:0] py;
      logic [WORD_W-1:0] ex;
      logic [WORD_W-1:0] ey;
      logic              run_end;
   } entry_type;

   // Up to two commands pushed by the parser for one accepted word
   typedef struct packed {
      logic      valid0;
      logic      valid1;
      entry_type ent0;
      entry_type ent1;
   } push_type;

endpackage

// ===== rtl/gord_front.sv =====
// Outline parser: classifies each buffer word and pushes the path commands it causes.
module gord_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gord_pkg::WORD_W-1:0]         req_tdata,
   input  logic                                req_tlast,
   input  logic                                space_ok,
   output gord_pkg::push_type                  push
);

   // Parse phases
   localparam logic [2:0] PH_HDR_LEN  = 3'd0;
   localparam logic [2:0] PH_HDR_TYPE = 3'd1;
   localparam logic [2:0] PH_START_X  = 3'd2;
   localparam logic [2:0] PH_START_Y  = 3'd3;
   localparam logic [2:0] PH_CURVE    = 3'd4;
   localparam logic [2:0] PH_PT_X     = 3'd5;
   localparam logic [2:0] PH_PT_Y     = 3'd6;

   // Command codes
   localparam logic [1:0] CMD_MOVE  = 2'd0;
   localparam logic [1:0] CMD_LINE  = 2'd1;
   localparam logic [1:0] CMD_CURVE = 2'd2;
   localparam logic [1:0] CMD_CLOSE = 2'd3;

   // Curve record types
   localparam logic [15:0] PRIM_LINE    = 16'd1;
   localparam logic [15:0] PRIM_QSPLINE = 16'd2;

   logic [2:0]  phase_ff,   phase_in;
   logic [29:0] wl_ff,      wl_in;
   logic [15:0] kind_ff,    kind_in;
   logic [15:0] pts_ff,     pts_in;
   logic [15:0] idx_ff,     idx_in;
   logic [31:0] held_x_ff,  held_x_in;
   logic [31:0] prev_x_ff,  prev_x_in;
   logic [31:0] prev_y_ff,  prev_y_in;
   logic        open_ff,    open_in;

   logic                accept;
   logic [29:0]         wl_dec;
   logic [2:0]          bound;
   logic [15:0]         pts_dec;
   logic [31:0]         mid_x;
   logic [31:0]         mid_y;
   logic                p_valid;
   logic                c_valid;
   gord_pkg::entry_type p_ent;
   gord_pkg::entry_type c_ent;

   // Signed midpoint at 33 bits, truncated toward zero
   function automatic logic [31:0] midpoint(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      return s[32:1] + {31'd0, s[32] & s[0]};
   endfunction

   assign req_tready = space_ok;
   assign accept     = req_tvalid & space_ok;

   assign wl_dec  = (phase_ff != PH_HDR_LEN && wl_ff != 30'd0) ? wl_ff - 30'd1 : wl_ff;
   assign bound   = (wl_dec == 30'd0) ? PH_HDR_LEN : PH_CURVE;
   assign pts_dec = pts_ff - 16'd1;
   assign mid_x   = midpoint(prev_x_ff, held_x_ff);
   assign mid_y   = midpoint(prev_y_ff, req_tdata);

   // Parser next state and command generation
   always_comb begin
      phase_in  = phase_ff;
      wl_in     = wl_ff;
      kind_in   = kind_ff;
      pts_in    = pts_ff;
      idx_in    = idx_ff;
      held_x_in = held_x_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      open_in   = open_ff;
      p_valid   = 1'b0;
      p_ent     = '0;
      c_valid   = 1'b0;
      c_ent     = '0;
      c_ent.cmd = CMD_CLOSE;
      if (accept) begin
         wl_in = wl_dec;
         unique case (phase_ff)
            PH_HDR_TYPE: begin
               phase_in = PH_START_X;
            end
            PH_START_X: begin
               held_x_in = req_tdata;
               phase_in  = PH_START_Y;
            end
            PH_START_Y: begin
               p_valid  = 1'b1;
               p_ent.cmd = CMD_MOVE;
               p_ent.px  = held_x_ff;
               p_ent.py  = req_tdata;
               open_in  = 1'b1;
               phase_in = bound;
            end
            PH_CURVE: begin
               kind_in  = req_tdata[15:0];
               pts_in   = req_tdata[31:16];
               idx_in   = 16'd0;
               phase_in = (req_tdata[31:16] == 16'd0) ? bound : PH_PT_X;
            end
            PH_PT_X: begin
               held_x_in = req_tdata;
               phase_in  = PH_PT_Y;
            end
            PH_PT_Y: begin
               pts_in = pts_dec;
               if (kind_ff == PRIM_LINE) begin
                  p_valid   = 1'b1;
                  p_ent.cmd = CMD_LINE;
                  p_ent.px  = held_x_ff;
                  p_ent.py  = req_tdata;
               end else if (kind_ff == PRIM_QSPLINE && idx_ff != 16'd0) begin
                  p_valid   = 1'b1;
                  p_ent.cmd = CMD_CURVE;
                  p_ent.px  = prev_x_ff;
                  p_ent.py  = prev_y_ff;
                  p_ent.ex  = (pts_dec != 16'd0) ? mid_x : held_x_ff;
                  p_ent.ey  = (pts_dec != 16'd0) ? mid_y : req_tdata;
               end
               prev_x_in = held_x_ff;
               prev_y_in = req_tdata;
               idx_in    = idx_ff + 16'd1;
               phase_in  = (pts_dec == 16'd0) ? bound : PH_PT_X;
            end
            default: begin
               // header length word, closes an open subpath
               if (open_ff) begin
                  p_valid   = 1'b1;
                  p_ent.cmd = CMD_CLOSE;
                  open_in   = 1'b0;
               end
               wl_in    = (req_tdata[31:2] != 30'd0) ? req_tdata[31:2] - 30'd1 : 30'd0;
               phase_in = PH_HDR_TYPE;
            end
         endcase
         // end of buffer: final close and parser cleared
         if (req_tlast) begin
            c_valid   = open_in;
            open_in   = 1'b0;
            phase_in  = PH_HDR_LEN;
            wl_in     = '0;
            kind_in   = '0;
            pts_in    = '0;
            idx_in    = '0;
            held_x_in = '0;
            prev_x_in = '0;
            prev_y_in = '0;
         end
      end
   end

   // Pack commands into queue slots, run_end on the last one
   always_comb begin
      push = '0;
      if (p_valid) begin
         push.valid0       = 1'b1;
         push.ent0         = p_ent;
         push.ent0.run_end = ~c_valid;
         push.valid1       = c_valid;
         push.ent1         = c_ent;
         push.ent1.run_end = 1'b1;
      end else if (c_valid) begin
         push.valid0       = 1'b1;
         push.ent0         = c_ent;
         push.ent0.run_end = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR_LEN;
         wl_ff     <= '0;
         kind_ff   <= '0;
         pts_ff    <= '0;
         idx_ff    <= '0;
         held_x_ff <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         open_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         wl_ff     <= wl_in;
         kind_ff   <= kind_in;
         pts_ff    <= pts_in;
         idx_ff    <= idx_in;
         held_x_ff <= held_x_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         open_ff   <= open_in;
      end
   end

endmodule

// ===== rtl/gord_queue.sv =====
// Command queue between parser and output stage: two writes, one read per cycle.
module gord_queue #(
   parameter int DEPTH = gord_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  gord_pkg::push_type  push,
   output logic                space_ok,
   output logic                head_valid,
   output gord_pkg::entry_type head,
   input  logic                pop
);

   localparam int PtrW   = $clog2(DEPTH);
   localparam int CountW = $clog2(DEPTH + 1);

   gord_pkg::entry_type entries_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]   count_ff,  count_in;
   logic [PtrW-1:0]     wr_ptr_next;

   // Room for the two commands one word can cause
   assign space_ok    = count_ff <= CountW'(DEPTH - 2);
   assign head_valid  = count_ff != '0;
   assign head        = entries_ff[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + PtrW'(1);

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push.valid0) + PtrW'(push.valid1);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      count_in  = count_ff + CountW'(push.valid0) + CountW'(push.valid1) - CountW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entries_ff[wr_ptr_ff] <= push.ent0;
      end
      if (push.valid1) begin
         entries_ff[wr_ptr_next] <= push.ent1;
      end
   end

   // Checks
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(DEPTH))
      else $error("command queue overfilled");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty command queue");

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      push.valid1 |-> (push.valid0 && !push.ent0.run_end && push.ent1.run_end))
      else $error("second slot pushed without a leading first slot");

endmodule

// ===== rtl/gord_back.sv =====
// Output stage: holds flip_y, applies the y flip and drives the result register.
module gord_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_wdata,
   input  logic                head_valid,
   input  gord_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [135:0]        rsp_tdata,
   output logic                rsp_tlast
);

   logic                flip_ff;
   logic                valid_ff, valid_in;
   gord_pkg::entry_type out_ff,   out_in;

   // Negate with saturation of the most negative value
   function automatic logic [31:0] flip_val(input logic en, input logic [31:0] v);
      logic [31:0] r;
      r = v;
      if (en) begin
         r = (v == 32'h8000_0000) ? 32'h7fff_ffff : 32'd0 - v;
      end
      return r;
   endfunction

   // Load a new beat when the register is empty or being taken
   assign pop = head_valid & (~valid_ff | rsp_tready);

   always_comb begin
      valid_in = valid_ff & ~rsp_tready;
      out_in   = out_ff;
      if (pop) begin
         valid_in  = 1'b1;
         out_in    = head;
         out_in.py = flip_val(flip_ff, head.py);
         out_in.ey = flip_val(flip_ff, head.ey);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff  <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            flip_ff <= csr_wdata;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = out_ff.run_end;
   assign rsp_tdata  = {6'd0, out_ff.ey, out_ff.ex, out_ff.py, out_ff.px, out_ff.cmd};

endmodule

// ===== rtl/glyph_outline_record_decoder.sv =====
// Top level of the glyph outline record decoder: parser, command queue and output stage.
//
// Use: the outline buffer enters on req_* as one 32-bit little-endian word per beat,
// req_tlast set on the buffer's final word. Path commands leave on rsp_* one per beat:
// command, point and end coordinates in rsp_tdata, rsp_tlast on the last command a word
// causes. csr_we/csr_wdata write flip_y (reset value 1) while the block is idle.
// Throughput: one word per cycle while req_tready is high. A word causing two commands (a
// move, line or curve followed by the final close on the buffer's last word) leaves as two
// output beats; the queue between parser and output absorbs this, and req_tready stays high
// while it has room for two more commands.
// Path: the parser pushes a word's commands into the queue at its accept edge; the first
// is loaded into the output register when it is empty or being taken, then shown on rsp_*.
// Reset: parser returns to the polygon length word, no subpath open, queue and output
// register empty, flip_y set.
// Stall: when rsp_tready is low the output register holds its beat, the queue fills and
// req_tready drops once fewer than two entries are free; nothing is lost.
module glyph_outline_record_decoder #(
   parameter int QUEUE_DEPTH = gord_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_wdata,      // flip_y
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,      // word
   input  logic         req_tlast,      // last_word
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,      // command[1:0], point_x, point_y, end_x, end_y, zero pad
   output logic         rsp_tlast       // run_end
);

   gord_pkg::push_type  push;
   gord_pkg::entry_type head;
   logic                space_ok;
   logic                head_valid;
   logic                pop;

   gord_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .space_ok   (space_ok),
      .push       (push)
   );

   gord_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space_ok   (space_ok),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   gord_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
